FILE: rtl/keyed_slot_allocator_top_defines.svh
// Assertion macros for the keyed slot allocator.
`ifndef KEYED_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define KEYED_SLOT_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ksa_pkg.sv
// Types, codes and helpers for the keyed slot allocator.
package ksa_pkg;

    localparam int KEY_DIGITS    = 6;
    localparam int DIGIT_W       = 4;
    localparam int KEY_W         = KEY_DIGITS * DIGIT_W;
    localparam int CLOSE_LIMIT   = 5;
    localparam int SLOT_W        = 6;
    localparam int SLOTS_DEFAULT = 32;

    typedef enum logic [0:0] {
        FUNC_ALLOC   = 1'b0,
        FUNC_RELEASE = 1'b1
    } t_func;

    typedef enum logic [2:0] {
        STS_ALLOCATED = 3'd0,
        STS_RELEASED  = 3'd1,
        STS_NO_FREE   = 3'd2,
        STS_TOO_CLOSE = 3'd3,
        STS_NO_MATCH  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_func             func;
        logic [KEY_W-1:0]  key_bcd;
    } t_in_item;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] free_count;
    } t_out_item;

    // True when a and b agree in at least CLOSE_LIMIT digit positions.
    function automatic logic keys_close(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b);
        logic [2:0] n;
        n = '0;
        for (int d = 0; d < KEY_DIGITS; d++) begin
            if (a[d*DIGIT_W +: DIGIT_W] == b[d*DIGIT_W +: DIGIT_W]) begin
                n = n + 3'd1;
            end
        end
        return (n >= 3'(CLOSE_LIMIT));
    endfunction

endpackage

FILE: rtl/keyed_slot_allocator_top.sv
// Keyed slot allocator: slot table in a synchronous key memory, scanned once per item.
//
// Allocates and releases numbered slots (1..SLOTS), each holding a six-digit
// key. An allocate item claims the next free slot after the one last given
// (round robin) unless some other slot's stored key agrees with the new key
// in five or more digit positions; a release item frees the lowest in-use slot
// whose key matches exactly. Each item yields one result with a status, the
// affected slot (0 if none) and the free-slot count after the item.
// Each item passes through accept in idle, a scan step that streams the key
// memory through its single read port, a last step for the final compare and
// a finish step that writes back and posts the result.
// The input is accepted again only once the block is back in idle; a posted
// result may sit in the output register while the next item is scanned, and
// the block holds in the finish step only if that register is still full.
// Keys that were never written read as zero through a per-slot written bit,
// so no clearing pass is needed after reset.
module keyed_slot_allocator_top #(
    parameter int SLOTS = ksa_pkg::SLOTS_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ksa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ksa_pkg::t_out_item  o_out_item
);
    import ksa_pkg::*;

    `include "keyed_slot_allocator_top_defines.svh"

    localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // FSM
    t_state r_state, n_state;

    // Request held for the whole scan
    t_in_item r_req;

    // Table state: in-use and written marks in flops, keys in memory
    logic [SLOTS-1:0]  r_in_use;
    logic [SLOTS-1:0]  r_written;
    logic [KEY_W-1:0]  r_mem [SLOTS];
    logic [SLOT_W-1:0] r_last_given;
    logic [SLOT_W-1:0] r_free_cnt;

    // Scan address, count and read pipeline
    logic [IDXW-1:0]   r_addr;
    logic [IDXW-1:0]   r_cnt;
    logic              r_rd_valid;
    logic [IDXW-1:0]   r_rd_idx;
    logic [KEY_W-1:0]  r_rd_key;

    // Scan results
    logic              r_found;
    logic              r_close;
    logic [IDXW-1:0]   r_hit_idx;

    // Output register
    logic              r_out_valid;
    t_out_item         r_out;

    // Control decode
    logic              accept;
    logic              rd_en;
    logic              finish_go;
    logic              scan_done;
    logic [IDXW-1:0]   start_idx;
    logic [IDXW-1:0]   addr_inc;
    logic [KEY_W-1:0]  ent_key;
    logic              ent_used;
    logic              is_alloc;
    logic              alloc_ok;

    assign is_alloc  = (r_req.func == FUNC_ALLOC);
    assign scan_done = (r_cnt == IDXW'(SLOTS - 1));
    assign addr_inc  = (r_addr == IDXW'(SLOTS - 1)) ? '0 : r_addr + 1'b1;
    // last_given is 1-based; slot SLOTS wraps back to index 0
    assign start_idx = (r_last_given >= SLOT_W'(SLOTS)) ? '0 : r_last_given[IDXW-1:0];
    assign ent_key   = r_written[r_rd_idx] ? r_rd_key : '0;
    assign ent_used  = r_in_use[r_rd_idx];
    assign alloc_ok  = is_alloc && r_found && !r_close;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_in_valid) n_state = ST_SCAN;
            ST_SCAN:   if (scan_done) n_state = ST_LAST;
            ST_LAST:   n_state = ST_FINISH;
            ST_FINISH: if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_ready = 1'b0;
        rd_en      = 1'b0;
        finish_go  = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_ready = 1'b1;
            ST_SCAN:   rd_en = 1'b1;
            ST_LAST:   ;
            ST_FINISH: finish_go = !r_out_valid || i_out_ready;
            default:   ;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (finish_go && alloc_ok) begin
            r_mem[r_hit_idx] <= r_req.key_bcd;
        end
        if (rd_en) begin
            r_rd_key <= r_mem[r_addr];
        end
    end

    // Request capture, scan address and read pipeline
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req  <= i_in_item;
            r_addr <= (i_in_item.func == FUNC_ALLOC) ? start_idx : '0;
            r_cnt  <= '0;
        end else if (rd_en) begin
            r_addr <= addr_inc;
            r_cnt  <= r_cnt + 1'b1;
        end
        r_rd_idx <= r_addr;
    end

    // Per-entry evaluation as read data returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_found    <= 1'b0;
            r_close    <= 1'b0;
        end else begin
            r_rd_valid <= rd_en;
            if (accept) begin
                r_found <= 1'b0;
                r_close <= 1'b0;
            end else if (r_rd_valid) begin
                if (is_alloc) begin
                    // First free slot in scan order is the pick; it is
                    // left out of the closeness check.
                    if (!r_found && !ent_used) begin
                        r_found   <= 1'b1;
                        r_hit_idx <= r_rd_idx;
                    end else if (keys_close(ent_key, r_req.key_bcd)) begin
                        r_close <= 1'b1;
                    end
                end else if (!r_found && ent_used && ent_key == r_req.key_bcd) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                end
            end
        end
    end

    // Write back table state and post the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use     <= '0;
            r_written    <= '0;
            r_last_given <= '0;
            r_free_cnt   <= SLOT_W'(SLOTS);
            r_out_valid  <= 1'b0;
        end else begin
            if (finish_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (finish_go) begin
                if (is_alloc) begin
                    if (!r_found) begin
                        r_last_given     <= '0;
                        r_out.status     <= STS_NO_FREE;
                        r_out.slot       <= '0;
                        r_out.free_count <= r_free_cnt;
                    end else if (r_close) begin
                        r_out.status     <= STS_TOO_CLOSE;
                        r_out.slot       <= '0;
                        r_out.free_count <= r_free_cnt;
                    end else begin
                        r_in_use[r_hit_idx]  <= 1'b1;
                        r_written[r_hit_idx] <= 1'b1;
                        r_last_given         <= SLOT_W'(r_hit_idx) + 1'b1;
                        r_free_cnt           <= r_free_cnt - 1'b1;
                        r_out.status         <= STS_ALLOCATED;
                        r_out.slot           <= SLOT_W'(r_hit_idx) + 1'b1;
                        r_out.free_count     <= r_free_cnt - 1'b1;
                    end
                end else if (r_found) begin
                    r_in_use[r_hit_idx] <= 1'b0;
                    r_free_cnt          <= r_free_cnt + 1'b1;
                    r_out.status        <= STS_RELEASED;
                    r_out.slot          <= SLOT_W'(r_hit_idx) + 1'b1;
                    r_out.free_count    <= r_free_cnt + 1'b1;
                end else begin
                    r_out.status     <= STS_NO_MATCH;
                    r_out.slot       <= '0;
                    r_out.free_count <= r_free_cnt;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Free count tracks the in-use marks
    `KSA_ASSERT_NOW(a_free_cnt, i_clk, i_rst_n, 1'b1, (32'(r_free_cnt) == 32'(SLOTS - $countones(r_in_use))), "free count out of step with in-use marks")
    // Round-robin pointer never runs past the last slot
    `KSA_ASSERT_NOW(a_last_range, i_clk, i_rst_n, 1'b1, (r_last_given <= SLOT_W'(SLOTS)), "last given slot out of range")
    // A successful allocation leaves its slot marked in use and written
    `KSA_ASSERT_NEXT(a_alloc_mark, i_clk, i_rst_n, (finish_go && alloc_ok), (r_in_use[r_hit_idx] && r_written[r_hit_idx]), "allocated slot not marked")

endmodule
